FILE: sv/hbp_pkg.sv
// Shared constants, codes and helper functions for the hybrid branch predictor.
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  localparam int MAX_CHOOSER_BITS = 12;
  localparam int MAX_GSHARE_BITS  = 14;
  localparam int MAX_BIMODAL_BITS = 14;

  localparam int CFG_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W    = 14;
  localparam int CH_IDX_W = MAX_CHOOSER_BITS;
  localparam int CNT_W    = 32;
  localparam int PC_W     = 32;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 72;

  // Table sweep after reset covers the largest table.
  localparam int CLR_W = IDX_W;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_RESET_PRED = 2'd2;
  localparam ctr_t CTR_RESET_CHSR = 2'd1;
  localparam ctr_t CTR_MAX        = 2'd3;
  localparam ctr_t CTR_MIN        = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHOOSER_BITS = 2'd0,
    CFG_GSHARE_BITS  = 2'd1,
    CFG_HISTORY_BITS = 2'd2,
    CFG_BIMODAL_BITS = 2'd3
  } cfg_idx_t;

  // Saturating 2-bit counter step.
  function automatic ctr_t bump(input ctr_t ctr, input logic up);
    if (up) begin
      return (ctr == CTR_MAX) ? CTR_MAX : ctr_t'(ctr + 2'd1);
    end
    return (ctr == CTR_MIN) ? CTR_MIN : ctr_t'(ctr - 2'd1);
  endfunction

  // Low-bit mask over the index width; saturates to all ones.
  function automatic logic [IDX_W-1:0] low_mask(input logic [CFG_W-1:0] bits);
    return ~({IDX_W{1'b1}} << bits);
  endfunction

endpackage

`default_nettype wire

FILE: sv/hybrid_branch_predictor.sv
// Tournament branch predictor: bimodal and gshare tables with a chooser.
// Stages: index/read registered on the input transfer, then update and output register.
// Throughput: one branch per cycle while the output is not stalled; a one-entry write bypass
// per table covers back-to-back hits on the same counter, and an output register decouples
// the result side. Reset: history and counts clear at once; then a sweep writes the counter
// tables (2 in bimodal/gshare, 1 in chooser) with s_tready low. Config writes still land.
`timescale 1ns / 1ps
`default_nettype none

module hybrid_branch_predictor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [hbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [hbp_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // [31:0] branch_pc, [32] taken, [39:33] zero
  input  wire logic [hbp_pkg::IN_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [0] predicted_taken, [1] mispredicted, [2] chose_gshare,
  // [34:3] prediction_total, [66:35] misprediction_total, [71:67] zero
  output logic [hbp_pkg::OUT_W-1:0]        m_tdata
);
  import hbp_pkg::*;

  localparam int BI_DEPTH = 1 << MAX_BIMODAL_BITS;
  localparam int GS_DEPTH = 1 << MAX_GSHARE_BITS;
  localparam int CH_DEPTH = 1 << MAX_CHOOSER_BITS;

  // configuration
  logic [CFG_W-1:0] cfg_k, cfg_m1, cfg_n, cfg_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k  <= 4'd8;
      cfg_m1 <= 4'd12;
      cfg_n  <= 4'd8;
      cfg_m2 <= 4'd12;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CHOOSER_BITS: cfg_k  <= cfg_wdata;
        CFG_GSHARE_BITS:  cfg_m1 <= cfg_wdata;
        CFG_HISTORY_BITS: cfg_n  <= cfg_wdata;
        CFG_BIMODAL_BITS: cfg_m2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] k_eff, m1_eff, n_lo, n_eff, m2_eff, low_bits;

  always_comb begin
    k_eff  = (cfg_k > CFG_W'(MAX_CHOOSER_BITS)) ? CFG_W'(MAX_CHOOSER_BITS) : cfg_k;
    m2_eff = (cfg_m2 > CFG_W'(MAX_BIMODAL_BITS)) ? CFG_W'(MAX_BIMODAL_BITS) : cfg_m2;
    m1_eff = (cfg_m1 > CFG_W'(MAX_GSHARE_BITS)) ? CFG_W'(MAX_GSHARE_BITS) : cfg_m1;
    if (m1_eff == '0) m1_eff = CFG_W'(1);
    n_lo   = (cfg_n == '0) ? CFG_W'(1) : cfg_n;
    n_eff  = (n_lo > m1_eff) ? m1_eff : n_lo;
    low_bits = m1_eff - n_eff;
  end

  // clear sweep
  logic             clr_busy;
  logic [CLR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + CLR_W'(1);
      if (clr_addr == {CLR_W{1'b1}}) clr_busy <= 1'b0;
    end
  end

  // handshake
  logic s1_valid, s1_adv, s_xfer;

  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clr_busy && (!s1_valid || s1_adv);
  assign s_xfer   = s_tvalid && s_tready;

  // index computation
  logic [IDX_W-1:0]    ghist, hist_eff, hist_next, hmask, word_sh, upper, ch_mask;
  logic [29:0]         word;
  logic [IDX_W-1:0]    bi_idx, gs_idx;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                in_taken;

  always_comb begin
    word      = s_tdata[PC_W-1:2];
    in_taken  = s_tdata[PC_W];
    hmask     = low_mask(n_eff);
    hist_eff  = ghist & hmask;
    word_sh   = IDX_W'(word >> low_bits);
    upper     = hist_eff ^ (word_sh & hmask);
    gs_idx    = ((upper << low_bits) | (word[IDX_W-1:0] & low_mask(low_bits)))
                & low_mask(m1_eff);
    bi_idx    = word[IDX_W-1:0] & low_mask(m2_eff);
    ch_mask   = low_mask(k_eff);
    ch_idx    = word[CH_IDX_W-1:0] & ch_mask[CH_IDX_W-1:0];
    hist_next = (IDX_W'(in_taken) << (n_eff - CFG_W'(1))) | (hist_eff >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ghist <= '0;
    end else if (s_xfer) begin
      ghist <= hist_next;
    end
  end

  // table write ports
  logic                bi_we, gs_we, ch_we;
  logic [IDX_W-1:0]    bi_waddr, gs_waddr;
  logic [CH_IDX_W-1:0] ch_waddr;
  ctr_t                bi_wdata, gs_wdata, ch_wdata;

  // memories
  ctr_t bi_mem [BI_DEPTH];
  ctr_t gs_mem [GS_DEPTH];
  ctr_t ch_mem [CH_DEPTH];
  ctr_t bi_rd, gs_rd, ch_rd;

  always_ff @(posedge clk) begin
    if (bi_we) bi_mem[bi_waddr] <= bi_wdata;
    if (s_xfer) bi_rd <= bi_mem[bi_idx];
  end

  always_ff @(posedge clk) begin
    if (gs_we) gs_mem[gs_waddr] <= gs_wdata;
    if (s_xfer) gs_rd <= gs_mem[gs_idx];
  end

  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_waddr] <= ch_wdata;
    if (s_xfer) ch_rd <= ch_mem[ch_idx];
  end

  // stage 1 registers
  logic                s1_taken;
  logic [IDX_W-1:0]    s1_bi_idx, s1_gs_idx;
  logic [CH_IDX_W-1:0] s1_ch_idx;
  logic                s1_bi_fwd, s1_gs_fwd, s1_ch_fwd;
  ctr_t                s1_bi_fv, s1_gs_fv, s1_ch_fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // A write landing on the same edge as the read is caught here.
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      s1_taken  <= in_taken;
      s1_bi_idx <= bi_idx;
      s1_gs_idx <= gs_idx;
      s1_ch_idx <= ch_idx;
      s1_bi_fwd <= bi_we && (bi_waddr == bi_idx);
      s1_gs_fwd <= gs_we && (gs_waddr == gs_idx);
      s1_ch_fwd <= ch_we && (ch_waddr == ch_idx);
      s1_bi_fv  <= bi_wdata;
      s1_gs_fv  <= gs_wdata;
      s1_ch_fv  <= ch_wdata;
    end
  end

  // prediction and training
  ctr_t bi_ctr, gs_ctr, ch_ctr, ch_new;
  logic pred_bi, pred_gs, use_gs, pred, miss, ok_gs, ok_bi;

  always_comb begin
    bi_ctr  = s1_bi_fwd ? s1_bi_fv : bi_rd;
    gs_ctr  = s1_gs_fwd ? s1_gs_fv : gs_rd;
    ch_ctr  = s1_ch_fwd ? s1_ch_fv : ch_rd;
    pred_bi = bi_ctr[1];
    pred_gs = gs_ctr[1];
    use_gs  = ch_ctr[1];
    pred    = use_gs ? pred_gs : pred_bi;
    miss    = pred != s1_taken;
    ok_gs   = pred_gs == s1_taken;
    ok_bi   = pred_bi == s1_taken;
    ch_new  = (ok_gs != ok_bi) ? bump(ch_ctr, ok_gs) : ch_ctr;
  end

  always_comb begin
    bi_we    = clr_busy || (s1_adv && !use_gs);
    bi_waddr = clr_busy ? clr_addr : s1_bi_idx;
    bi_wdata = clr_busy ? CTR_RESET_PRED : bump(bi_ctr, s1_taken);
    gs_we    = clr_busy || (s1_adv && use_gs);
    gs_waddr = clr_busy ? clr_addr : s1_gs_idx;
    gs_wdata = clr_busy ? CTR_RESET_PRED : bump(gs_ctr, s1_taken);
    ch_we    = clr_busy || s1_adv;
    ch_waddr = clr_busy ? clr_addr[CH_IDX_W-1:0] : s1_ch_idx;
    ch_wdata = clr_busy ? CTR_RESET_CHSR : ch_new;
  end

  // running counts and output register
  logic [CNT_W-1:0] pred_cnt, miss_cnt, pred_cnt_next, miss_cnt_next;

  assign pred_cnt_next = pred_cnt + CNT_W'(1);
  assign miss_cnt_next = miss_cnt + CNT_W'(miss);

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_cnt <= '0;
      miss_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_adv) begin
        pred_cnt <= pred_cnt_next;
        miss_cnt <= miss_cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {5'd0, miss_cnt_next, pred_cnt_next, use_gs, miss, pred};
    end
  end

endmodule

`default_nettype wire

FILE: sv/hbp_checker.sv
// Port-level checks for the hybrid branch predictor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hbp_assert (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [hbp_pkg::OUT_W-1:0]     m_tdata
);
  import hbp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // table sweep keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input open during table sweep");

  // consecutive results count up by one
  a_pred_count: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && m_tready) && m_tvalid |->
      m_tdata[34:3] == $past(m_tdata[34:3]) + 32'd1)
    else $error("prediction total skipped");

  // miss total follows the miss flag
  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && m_tready) && m_tvalid |->
      m_tdata[66:35] == $past(m_tdata[66:35]) + 32'(m_tdata[1]))
    else $error("misprediction total inconsistent");

endmodule

bind hybrid_branch_predictor hbp_assert u_hbp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
